FILE: rtl/core/binary_to_decimal_ascii_defines.svh
// assertion macros for the binary to decimal ascii converter
// used by the top level only; needs nothing else
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, checked at every rising clock edge outside reset
`define BTDA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BTDA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/btda_pkg.sv
// shared constants and control types of the binary to decimal ascii converter
// used by btda_ctrl, btda_datapath and binary_to_decimal_ascii
`timescale 1ns / 1ps
`default_nettype none

package btda_pkg;

   // port width of the input number and the bits actually converted
   localparam int VALUE_W    = 64;
   localparam int VALUE_BITS = 64;

   // decimal digits needed for VALUE_BITS bits: floor(n * log10(2)) + 1
   localparam int NUM_DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int BCD_W      = NUM_DIGITS * 4;

   localparam int CNT_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int DIG_W = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

   localparam int CHAR_W = 6;
   localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
   localparam logic [CHAR_W-1:0] ASCII_NINE = CHAR_W'(57);

   // controller to datapath
   typedef struct packed {
      logic load;     // take a new word into the shifter
      logic dabble;   // one double dabble step
      logic skip;     // drop a leading zero digit
      logic emit;     // move the top digit to the output register
      logic last;     // emitted digit is the final one of the number
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;   // output register can take a digit this cycle
      logic top_zero;   // most significant bcd digit is zero
   } status_type;

endpackage

`default_nettype wire

FILE: rtl/core/btda_datapath.sv
// datapath: binary shifter, bcd register with add-3 correction, output register
// depends on btda_pkg
`timescale 1ns / 1ps
`default_nettype none

module btda_datapath (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [btda_pkg::VALUE_W-1:0]     req_value,
   input  wire btda_pkg::cmd_type                cmd,
   output btda_pkg::status_type                  status,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [btda_pkg::CHAR_W-1:0]           rsp_digit_char,
   output logic                                  rsp_last_digit
);

   logic [btda_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic [btda_pkg::BCD_W-1:0]      bcd_ff, bcd_in;
   logic [btda_pkg::BCD_W-1:0]      bcd_adj;
   logic                            valid_ff, valid_in;
   logic [btda_pkg::CHAR_W-1:0]     char_ff, char_in;
   logic                            last_ff, last_in;
   logic [3:0]                      top_digit;

   assign top_digit = bcd_ff[btda_pkg::BCD_W-1 -: 4];

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < btda_pkg::NUM_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   always_comb begin
      value_in = value_ff;
      bcd_in   = bcd_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      valid_in = valid_ff && rsp_stall;
      if (cmd.load) begin
         value_in = req_value[btda_pkg::VALUE_BITS-1:0];
         bcd_in   = '0;
      end else if (cmd.dabble) begin
         value_in = value_ff << 1;
         bcd_in   = {bcd_adj[btda_pkg::BCD_W-2:0], value_ff[btda_pkg::VALUE_BITS-1]};
      end else if (cmd.skip || cmd.emit) begin
         bcd_in = {bcd_ff[btda_pkg::BCD_W-5:0], 4'b0000};
      end
      if (cmd.emit) begin
         valid_in = 1'b1;
         char_in  = btda_pkg::ASCII_ZERO + {{(btda_pkg::CHAR_W-4){1'b0}}, top_digit};
         last_in  = cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign status.out_free = !valid_ff || !rsp_stall;
   assign status.top_zero = (top_digit == 4'd0);

   assign rsp_valid      = valid_ff;
   assign rsp_digit_char = char_ff;
   assign rsp_last_digit = last_ff;

endmodule

`default_nettype wire

FILE: rtl/core/btda_ctrl.sv
// controller: sequences load, bit-serial conversion, leading zero skip and emission
// depends on btda_pkg
`timescale 1ns / 1ps
`default_nettype none

module btda_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire btda_pkg::status_type status,
   output btda_pkg::cmd_type         cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   logic [btda_pkg::CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [btda_pkg::DIG_W-1:0]  dig_cnt_ff, dig_cnt_in;
   logic                        started_ff, started_in;
   logic                        final_digit;

   assign final_digit = (dig_cnt_ff == '0);

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = btda_pkg::CNT_W'(btda_pkg::VALUE_BITS - 1);
               state_in   = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.dabble = 1'b1;
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = btda_pkg::DIG_W'(btda_pkg::NUM_DIGITS - 1);
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - btda_pkg::CNT_W'(1);
            end
         end
         ST_EMIT: begin
            // leading zeros are dropped, but the ones digit always goes out
            if (!started_ff && status.top_zero && !final_digit) begin
               cmd.skip   = 1'b1;
               dig_cnt_in = dig_cnt_ff - btda_pkg::DIG_W'(1);
            end else if (status.out_free) begin
               cmd.emit   = 1'b1;
               cmd.last   = final_digit;
               started_in = 1'b1;
               dig_cnt_in = dig_cnt_ff - btda_pkg::DIG_W'(1);
               if (final_digit) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
         dig_cnt_ff <= '0;
         started_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
         dig_cnt_ff <= dig_cnt_in;
         started_ff <= started_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/binary_to_decimal_ascii.sv
// binary to decimal ascii converter: top level, controller plus datapath
// depends on btda_pkg, btda_ctrl, btda_datapath, binary_to_decimal_ascii_defines.svh
//
// usage:
//  - req channel: one unsigned 64-bit word in req_value per accepted word
//    (req_valid high, req_stall low at the clock edge)
//  - rsp channel: one word per decimal digit, most significant first, no leading
//    zeros; rsp_digit_char is the ascii code '0'..'9', rsp_last_digit marks the
//    ones digit. zero gives a single '0'
//  - conversion is bit-serial double dabble, one input bit per cycle
//  - emission then walks the 20 digit slots: up to 19 leading zero slots are
//    skipped, then each remaining slot is sent as one digit
//  - one number in flight
//  - req_stall is high from the cycle after accept until the last digit has
//    moved into the output register, so the next word can be taken while
//    that last digit still waits
//  - rsp_stall holds the output register and freezes emission; conversion
//    itself does not wait
//  - reset (synchronous, active high) returns to idle and drops rsp_valid
`timescale 1ns / 1ps
`default_nettype none
`include "binary_to_decimal_ascii_defines.svh"

module binary_to_decimal_ascii (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [btda_pkg::VALUE_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [btda_pkg::CHAR_W-1:0]        rsp_digit_char,
   output logic                               rsp_last_digit
);

   btda_pkg::cmd_type    cmd;
   btda_pkg::status_type status;
   logic [3:0]           cmd_vec;

   btda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   btda_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_value      (req_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   assign cmd_vec = {cmd.load, cmd.dabble, cmd.skip, cmd.emit};

   `BTDA_ASSERT_IMP(a_cmd_exclusive, clock, reset, 1'b1, $onehot0(cmd_vec), "commands overlap")
   `BTDA_ASSERT_IMP(a_emit_free, clock, reset, cmd.emit, !(rsp_valid && rsp_stall), "emit over held word")
   `BTDA_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && !req_stall, req_stall, "second word taken")
   `BTDA_ASSERT_IMP(a_char_range, clock, reset, rsp_valid, (rsp_digit_char >= btda_pkg::ASCII_ZERO) && (rsp_digit_char <= btda_pkg::ASCII_NINE), "bad digit")

endmodule

`default_nettype wire
